FILE: sv/assert_macros.svh
// Assertion macros shared by the line threshold RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ARLT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ARLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/arlt_pkg.sv
// Shared types, sizes and command codes of the ambient rejecting line threshold block.
`timescale 1ns / 1ps

package arlt_pkg;

	localparam int CHANNELS = 8;
	localparam int COLORS   = 3;
	localparam int ROUNDS   = 10;

	localparam int CMD_W    = 2;
	localparam int COLOR_W  = 2;
	localparam int CHAN_W   = 3;
	localparam int SAMPLE_W = 8;
	localparam int WEIGHT_W = 2;
	localparam int THR_W    = 8;
	localparam int MASK_W   = 8;
	localparam int SUM_W    = 16;

	localparam logic [CMD_W-1:0] CMD_DETECT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_TWO   = 2'd2;
	localparam logic [WEIGHT_W-1:0] WEIGHT_THREE = 2'd3;

	// Division of the calibration sum by ROUNDS as a multiply by a rounded-up reciprocal.
	localparam int AVG_SHIFT  = SUM_W + $clog2(ROUNDS);
	localparam int AVG_MUL_W  = SUM_W + 1;
	localparam int AVG_PROD_W = AVG_SHIFT + SUM_W;
	localparam longint AVG_MUL_L = ((longint'(1) << AVG_SHIFT) + ROUNDS - 1) / ROUNDS;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(AVG_MUL_L);

	// Blend of the old threshold and the average, and its division by three.
	localparam int BLEND_W    = SUM_W + 1;
	localparam int DIV3_SHIFT = BLEND_W + 2;
	localparam int DIV3_MUL_W = BLEND_W + 1;
	localparam int DIV3_PROD_W = DIV3_SHIFT + BLEND_W;
	localparam longint DIV3_MUL_L = ((longint'(1) << DIV3_SHIFT) + 2) / 3;
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(DIV3_MUL_L);

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [COLOR_W-1:0]  color;
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] dark_sample;
		logic [SAMPLE_W-1:0] lit_sample;
		logic [WEIGHT_W-1:0] weight;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [MASK_W-1:0] line_mask;
		logic [THR_W-1:0]  threshold_now;
	} rsp_t;

endpackage

FILE: sv/arlt_calc.sv
// Threshold, calibration sum and line mask state with the per-request datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arlt_calc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  arlt_pkg::req_t req,
	output arlt_pkg::rsp_t rsp
);

	logic [arlt_pkg::THR_W-1:0]  thr_q [arlt_pkg::COLORS][arlt_pkg::CHANNELS];
	logic [arlt_pkg::SUM_W-1:0]  sum_q [arlt_pkg::CHANNELS];
	logic [arlt_pkg::SUM_W-1:0]  avg_q [arlt_pkg::CHANNELS];
	logic [arlt_pkg::MASK_W-1:0] mask_q;

	logic                              in_range;
	logic [arlt_pkg::THR_W-1:0]        thr;
	logic [arlt_pkg::SAMPLE_W:0]       diff;
	logic                              hit_det;
	logic [arlt_pkg::MASK_W-1:0]       mask_det;
	logic [arlt_pkg::SUM_W-1:0]        sum_acc;
	logic [arlt_pkg::AVG_PROD_W-1:0]   avg_prod;
	logic [arlt_pkg::SUM_W-1:0]        avg_acc;
	logic [arlt_pkg::BLEND_W-1:0]      blend;
	logic [arlt_pkg::DIV3_PROD_W-1:0]  div3_prod;
	logic [arlt_pkg::BLEND_W-1:0]      quot;
	logic [arlt_pkg::THR_W-1:0]        thr_new;

	always_comb begin
		in_range = (int'(req.color) < arlt_pkg::COLORS) &&
			(int'(req.channel) < arlt_pkg::CHANNELS);
		thr = in_range ? thr_q[req.color][req.channel] : '0;

		diff = {1'b0, req.lit_sample} - {1'b0, req.dark_sample};
		hit_det = !diff[arlt_pkg::SAMPLE_W] && (diff[arlt_pkg::SAMPLE_W-1:0] > thr);
		if (req.channel == '0) begin
			mask_det = arlt_pkg::MASK_W'(hit_det);
		end else begin
			mask_det = mask_q | (arlt_pkg::MASK_W'(hit_det) << req.channel);
		end

		sum_acc = sum_q[req.channel] + arlt_pkg::SUM_W'(req.lit_sample) -
			arlt_pkg::SUM_W'(req.dark_sample);
		avg_prod = arlt_pkg::AVG_PROD_W'(sum_acc) * arlt_pkg::AVG_PROD_W'(arlt_pkg::AVG_MUL);
		avg_acc = avg_prod[arlt_pkg::AVG_SHIFT +: arlt_pkg::SUM_W];

		case (req.weight)
			arlt_pkg::WEIGHT_TWO: blend = arlt_pkg::BLEND_W'(thr) +
				arlt_pkg::BLEND_W'(avg_q[req.channel]);
			arlt_pkg::WEIGHT_THREE: blend = (arlt_pkg::BLEND_W'(thr) << 1) +
				arlt_pkg::BLEND_W'(avg_q[req.channel]);
			default: blend = arlt_pkg::BLEND_W'(avg_q[req.channel]);
		endcase

		div3_prod = arlt_pkg::DIV3_PROD_W'(blend) *
			arlt_pkg::DIV3_PROD_W'(arlt_pkg::DIV3_MUL);
		case (req.weight)
			arlt_pkg::WEIGHT_TWO:   quot = blend >> 1;
			arlt_pkg::WEIGHT_THREE: quot = div3_prod[arlt_pkg::DIV3_SHIFT +: arlt_pkg::BLEND_W];
			default:                quot = blend;
		endcase
		thr_new = quot[arlt_pkg::THR_W-1:0];

		rsp.hit = 1'b0;
		rsp.line_mask = mask_q;
		rsp.threshold_now = thr;
		case (req.cmd)
			arlt_pkg::CMD_DETECT: begin
				if (in_range) begin
					rsp.hit = hit_det;
					rsp.line_mask = mask_det;
				end
			end
			arlt_pkg::CMD_COMMIT: begin
				if (in_range) begin
					rsp.threshold_now = thr_new;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int c = 0; c < arlt_pkg::COLORS; c++) begin
				for (int n = 0; n < arlt_pkg::CHANNELS; n++) begin
					thr_q[c][n] <= '0;
				end
			end
			for (int n = 0; n < arlt_pkg::CHANNELS; n++) begin
				sum_q[n] <= '0;
				avg_q[n] <= '0;
			end
		end else if (fire && in_range) begin
			case (req.cmd)
				arlt_pkg::CMD_DETECT: begin
					mask_q <= mask_det;
				end
				arlt_pkg::CMD_ACCUM: begin
					sum_q[req.channel] <= sum_acc;
					avg_q[req.channel] <= avg_acc;
				end
				arlt_pkg::CMD_COMMIT: begin
					thr_q[req.color][req.channel] <= thr_new;
					sum_q[req.channel] <= '0;
					avg_q[req.channel] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	`ARLT_ASSERT_NXT(a_commit_clears_sum, fire && in_range && req.cmd == arlt_pkg::CMD_COMMIT, sum_q[$past(req.channel)] == '0 && avg_q[$past(req.channel)] == '0, "Commit did not clear the calibration sum.")
	`ARLT_ASSERT_NXT(a_mask_restart, fire && in_range && req.cmd == arlt_pkg::CMD_DETECT && req.channel == '0, mask_q[arlt_pkg::MASK_W-1:1] == '0, "Line mask did not restart at channel zero.")

endmodule

FILE: sv/ambient_rejecting_line_threshold.sv
// Top level of the ambient rejecting line threshold block.
// Responses are registered: an accepted request waits in req_s1 and moves into rsp_q when it advances.
// Throughput: one request per cycle while rsp_stall is low; the single compute stage updates state as it passes.
// Reset: arst_n clears all thresholds, calibration sums and the line mask at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ambient_rejecting_line_threshold (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  arlt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output arlt_pkg::rsp_t rsp
);

	arlt_pkg::req_t req_s1;
	logic           valid_s1;
	arlt_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	arlt_pkg::rsp_t rsp_calc;
	logic           advance;
	logic           accept_in;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept_in = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	arlt_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.rsp    (rsp_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_calc;
		end
	end

	`ARLT_ASSERT_NXT(a_advance_gives_rsp, advance, rsp_valid_q, "A computed request produced no response.")
	`ARLT_ASSERT_IMP(a_refill_needs_advance, accept_in && valid_s1, advance, "Input stage overwritten before it moved on.")

endmodule

FILE: test/tb.sv
// Self-checking testbench for the ambient rejecting line threshold block.
`timescale 1ns / 1ps

module tb;
	import arlt_pkg::*;

	localparam logic [CMD_W-1:0]    CMD_UNUSED  = 2'd3;
	localparam logic [COLOR_W-1:0]  COLOR_RED   = 2'd0;
	localparam logic [COLOR_W-1:0]  COLOR_GREEN = 2'd1;
	localparam logic [COLOR_W-1:0]  COLOR_BLUE  = 2'd2;
	localparam logic [COLOR_W-1:0]  COLOR_NONE  = 2'd3;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 2'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 2'd1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_TARGET = 720;

	class threshold_scoreboard;
		logic [THR_W-1:0]  thresholds [COLORS*CHANNELS];
		logic [SUM_W-1:0]  cal_sums [CHANNELS];
		logic [MASK_W-1:0] line_mask;
		rsp_t              pending_readings [$];
		int                errors;
		int                checked;
		int                by_cmd [4];
		int                off_range;

		function new();
			foreach (thresholds[i]) thresholds[i] = '0;
			foreach (cal_sums[i]) cal_sums[i] = '0;
			line_mask = '0;
			errors = 0;
			checked = 0;
			off_range = 0;
			foreach (by_cmd[i]) by_cmd[i] = 0;
		endfunction

		function rsp_t predict_reading(req_t r);
			rsp_t o;
			int unsigned idx, avg, blend, div;
			logic [THR_W-1:0] thr;
			o = '0;
			if (r.color < COLORS && r.channel < CHANNELS) begin
				idx = r.color * CHANNELS + r.channel;
				thr = thresholds[idx];
				case (r.cmd)
				CMD_DETECT: begin
					o.hit = (r.lit_sample > r.dark_sample) && (r.lit_sample - r.dark_sample > thr);
					if (r.channel == 0)
						line_mask = {{(MASK_W-1){1'b0}}, o.hit};
					else
						line_mask[r.channel] = line_mask[r.channel] | o.hit;
				end
				CMD_ACCUM: begin
					cal_sums[r.channel] = cal_sums[r.channel] + r.lit_sample - r.dark_sample;
				end
				CMD_COMMIT: begin
					div = (r.weight == WEIGHT_ZERO) ? 1 : r.weight;
					avg = cal_sums[r.channel] / ROUNDS;
					blend = thr * (div - 1) + avg;
					thresholds[idx] = THR_W'(blend / div);
					cal_sums[r.channel] = '0;
				end
				default: ;
				endcase
				o.threshold_now = thresholds[idx];
			end
			o.line_mask = line_mask;
			return o;
		endfunction

		function void note_request(req_t r);
			by_cmd[r.cmd]++;
			if (r.color >= COLORS) off_range++;
			pending_readings.push_back(predict_reading(r));
		endfunction

		function void check_reading(rsp_t got);
			rsp_t want;
			checked++;
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected reading %h with none pending", $time, got);
				errors++;
				return;
			end
			want = pending_readings.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
				errors++;
			end
			if (got.line_mask !== want.line_mask) begin
				$display("%0t: line_mask expected %h, got %h", $time, want.line_mask,
					got.line_mask);
				errors++;
			end
			if (got.threshold_now !== want.threshold_now) begin
				$display("%0t: threshold_now expected %0d, got %0d", $time,
					want.threshold_now, got.threshold_now);
				errors++;
			end
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	threshold_scoreboard board = new();
	int  cycles = 0;
	int  sent = 0;
	int  stall_left = 0;
	bit  steady = 0;

	ambient_rejecting_line_threshold dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic [COLOR_W-1:0] color,
		logic [CHAN_W-1:0] channel, logic [SAMPLE_W-1:0] dark, logic [SAMPLE_W-1:0] lit,
		logic [WEIGHT_W-1:0] weight);
		req_t r;
		r.cmd = cmd;
		r.color = color;
		r.channel = channel;
		r.dark_sample = dark;
		r.lit_sample = lit;
		r.weight = weight;
		return r;
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
		sent++;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_readings();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d readings pending.", cycles,
				board.pending());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_reading(rsp);
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		logic [COLOR_W-1:0]  col;
		logic [CHAN_W-1:0]   ch;
		logic [SAMPLE_W-1:0] dark, lit;
		int kind, n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests: sample extremes, sum wrap, every weight and the ignored cases.
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd0, 8'd0, 8'd255, WEIGHT_ONE));
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd1, 8'd255, 8'd0, WEIGHT_ONE));
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd7, 8'd200, 8'd200, WEIGHT_ONE));
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd2, 8'd0, 8'd1, WEIGHT_ONE));
		send_req(make_req(CMD_ACCUM, COLOR_GREEN, 3'd3, 8'd255, 8'd0, WEIGHT_ONE));
		send_req(make_req(CMD_ACCUM, COLOR_GREEN, 3'd3, 8'd255, 8'd0, WEIGHT_ONE));
		send_req(make_req(CMD_COMMIT, COLOR_GREEN, 3'd3, 8'd0, 8'd0, WEIGHT_ONE));
		repeat (3) send_req(make_req(CMD_ACCUM, COLOR_BLUE, 3'd4, 8'd0, 8'd255, WEIGHT_ONE));
		send_req(make_req(CMD_COMMIT, COLOR_BLUE, 3'd4, 8'd0, 8'd0, WEIGHT_TWO));
		send_req(make_req(CMD_ACCUM, COLOR_BLUE, 3'd4, 8'd100, 8'd200, WEIGHT_ONE));
		send_req(make_req(CMD_COMMIT, COLOR_BLUE, 3'd4, 8'd0, 8'd0, WEIGHT_THREE));
		send_req(make_req(CMD_COMMIT, COLOR_RED, 3'd5, 8'd0, 8'd0, WEIGHT_ZERO));
		send_req(make_req(CMD_ACCUM, COLOR_RED, 3'd5, 8'd0, 8'd255, WEIGHT_ONE));
		send_req(make_req(CMD_COMMIT, COLOR_RED, 3'd5, 8'd0, 8'd0, WEIGHT_ZERO));
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd5, 8'd0, 8'd26, WEIGHT_ONE));
		send_req(make_req(CMD_DETECT, COLOR_RED, 3'd5, 8'd0, 8'd25, WEIGHT_ONE));
		send_req(make_req(CMD_UNUSED, COLOR_GREEN, 3'd3, 8'd255, 8'd255, WEIGHT_THREE));
		send_req(make_req(CMD_DETECT, COLOR_NONE, 3'd1, 8'd0, 8'd255, WEIGHT_ONE));
		send_req(make_req(CMD_ACCUM, COLOR_NONE, 3'd6, 8'd0, 8'd255, WEIGHT_ONE));
		send_req(make_req(CMD_COMMIT, COLOR_NONE, 3'd6, 8'd0, 8'd0, WEIGHT_ONE));
		send_req(make_req(CMD_DETECT, COLOR_BLUE, 3'd0, 8'd0, 8'd0, WEIGHT_ONE));
		drain_readings();

		// Random part: detect sweeps and calibration rounds with some noise between them.
		while (sent < RANDOM_TARGET) begin
			steady = ($urandom_range(0, 9) == 0);
			kind = $urandom_range(0, 99);
			col = ($urandom_range(0, 11) == 0) ? COLOR_NONE : 2'($urandom_range(0, 2));
			if (kind < 40) begin
				for (int c = 0; c < CHANNELS; c++) begin
					ch = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(c);
					dark = 8'($urandom);
					lit = ($urandom_range(0, 2) == 0) ? 8'($urandom)
						: 8'($urandom_range(dark, 255));
					send_req(make_req(CMD_DETECT, col, ch, dark, lit, 2'($urandom)));
				end
			end else if (kind < 75) begin
				ch = 3'($urandom);
				n = ($urandom_range(0, 2) == 0) ? ROUNDS : $urandom_range(1, 20);
				repeat (n) begin
					dark = 8'($urandom_range(0, 100));
					lit = ($urandom_range(0, 5) == 0) ? 8'($urandom)
						: 8'($urandom_range(dark, 255));
					send_req(make_req(CMD_ACCUM, COLOR_RED, ch, dark, lit, 2'($urandom)));
				end
				send_req(make_req(CMD_COMMIT, col, ch, 8'($urandom), 8'($urandom),
					2'($urandom)));
			end else begin
				repeat ($urandom_range(1, 4)) send_req(req_t'($urandom));
			end
			if ($urandom_range(0, 14) == 0)
				drain_readings();
		end

		steady = 0;
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d requests: %0d detect, %0d accumulate, %0d commit, %0d unused.",
			sent, board.by_cmd[CMD_DETECT], board.by_cmd[CMD_ACCUM],
			board.by_cmd[CMD_COMMIT], board.by_cmd[CMD_UNUSED]);
		$display("Checked %0d readings, %0d with an unknown colour, %0d mismatches.",
			board.checked, board.off_range, board.errors);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: ambient_rejecting_line_threshold.f
+incdir+sv
sv/arlt_pkg.sv
sv/arlt_calc.sv
sv/ambient_rejecting_line_threshold.sv
test/tb.sv
